// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions. Each use expects clk and rst_n in
// scope and is disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/sha1sh_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Constants, types and round functions shared by the hasher files.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int BLOCK_BYTES  = 64;
  localparam int BLOCK_WORDS  = BLOCK_BYTES / 4;
  localparam int DIGEST_WORDS = 5;
  localparam int WORD_IDX_W   = 3;
  localparam int ROUNDS       = 80;
  localparam int LEN_HI_WORD  = BLOCK_WORDS - 2;
  localparam int LEN_LO_WORD  = BLOCK_WORDS - 1;
  localparam int EXTRA_FILL   = 56;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_CHAIN [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef enum logic [2:0] {
    ST_IDLE,   // take bytes
    ST_PAD,    // write the 0x80 word
    ST_ZERO,   // zero the tail, place the length
    ST_LOAD,   // load working words, prefetch word 0
    ST_COMP,   // one round per cycle
    ST_FIN,    // fold working words into the chain
    ST_OUT     // emit digest beats
  } state_t;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR_A,
    GRP_MAJ,
    GRP_PAR_B
  } rnd_grp_t;

  function automatic logic [31:0] round_f(rnd_grp_t grp, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] res;
    case (grp)
      GRP_CH:  res = (b & c) | (~b & d);
      GRP_MAJ: res = (b & c) | (b & d) | (c & d);
      default: res = b ^ c ^ d;
    endcase
    return res;
  endfunction

  function automatic logic [31:0] round_k(rnd_grp_t grp);
    logic [31:0] res;
    case (grp)
      GRP_CH:    res = 32'h5a827999;
      GRP_PAR_A: res = 32'h6ed9eba1;
      GRP_MAJ:   res = 32'h8f1bbcdc;
      default:   res = 32'hca62c1d6;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/sha1sh_in_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher input channel
// Valid/ready channel carrying one message byte and its flags per beat.
// ----------------------------------------------------------------------------
interface sha1sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// ===== hw/rtl/sha1sh_out_if.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher result channel
// Valid/ready channel carrying one digest word and its position per beat.
// ----------------------------------------------------------------------------
interface sha1sh_out_if;
  logic                               valid;
  logic                               ready;
  logic [31:0]                        digest_word;
  logic [sha1sh_pkg::WORD_IDX_W-1:0]  word_index;
  logic                               last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-serial SHA-1 with a dual-port block buffer and one round per cycle.
// ----------------------------------------------------------------------------
// A message arrives one beat at a time on in_bus; a beat with byte_valid low
// carries no byte, and a beat with end_of_message high closes the message.
// In the idle state in_bus.ready is high and beats are taken back to back.
// When the 64th byte of a block lands the block is compressed, which holds
// in_bus.ready low while the hasher loads the working words and prefetches
// word 0 from the buffer, runs the 80 rounds and folds into the chain. An
// end beat then pads: the 0x80 word is written, then each tail word up to
// word 15, then a compression follows; if the pad lands at byte 56 or later
// a second all-zero block with the length is written and compressed. The
// five digest words leave on out_bus as five beats, index 0 first, and the
// hasher returns to the initial chain values for the next message. The round
// loop is bound by the single 32-bit five-operand adder.
// ----------------------------------------------------------------------------
module sha1_stream_hasher (
  input  logic               clk,
  input  logic               rst_n,
  sha1sh_in_if.sink          in_bus,
  sha1sh_out_if.source       out_bus
);

  // --------------------------------------------------------------------------
  // Block buffer: 16 x 32-bit words, one write and one registered read port.
  // Writes happen only while packing or padding, reads only while loading
  // and running rounds, so the state sequence keeps the two apart.
  // --------------------------------------------------------------------------
  logic [31:0] blk_mem [sha1sh_pkg::BLOCK_WORDS];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= blk_mem[mem_raddr];
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  sha1sh_pkg::state_t state_r, state_nxt;

  logic [5:0]  fill_r,     fill_nxt;      // bytes held in the current block
  logic [63:0] bitlen_r,   bitlen_nxt;    // message length in bits
  logic [31:0] acc_r,      acc_nxt;       // word being packed
  logic        end_pend_r, end_pend_nxt;  // end beat seen, pad after compress
  logic        pad_r,      pad_nxt;       // finishing the message
  logic        extra_r,    extra_nxt;     // length needs a block of its own
  logic [4:0]  wptr_r,     wptr_nxt;      // tail word pointer, bit 4 = done
  logic [6:0]  rnd_r,      rnd_nxt;
  logic [2:0]  oidx_r,     oidx_nxt;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0] sched_r   [sha1sh_pkg::BLOCK_WORDS];
  logic [31:0] sched_nxt [sha1sh_pkg::BLOCK_WORDS];
  logic [31:0] h_r       [sha1sh_pkg::DIGEST_WORDS];
  logic [31:0] h_nxt     [sha1sh_pkg::DIGEST_WORDS];

  logic in_fire, out_fire;

  assign in_fire  = in_bus.valid  & in_bus.ready;
  assign out_fire = out_bus.valid & out_bus.ready;

  // --------------------------------------------------------------------------
  // Byte placement: big-endian lane chosen by the low fill bits. A fresh word
  // starts from zero rather than the stale accumulator.
  // --------------------------------------------------------------------------
  logic [31:0] lane_byte, lane_pad, acc_base, put_word, pad_word;

  always_comb begin
    lane_byte = {in_bus.data_byte, 24'd0} >> {fill_r[1:0], 3'd0};
    lane_pad  = {sha1sh_pkg::PAD_BYTE, 24'd0} >> {fill_r[1:0], 3'd0};
    acc_base  = (fill_r[1:0] == 2'd0) ? 32'd0 : acc_r;
    put_word  = acc_base | lane_byte;
    pad_word  = acc_base | lane_pad;
  end

  // --------------------------------------------------------------------------
  // Round datapath
  // --------------------------------------------------------------------------
  sha1sh_pkg::rnd_grp_t grp;
  logic [31:0]          w_cur, t_sum;

  always_comb begin
    if (rnd_r < 7'd20) begin
      grp = sha1sh_pkg::GRP_CH;
    end else if (rnd_r < 7'd40) begin
      grp = sha1sh_pkg::GRP_PAR_A;
    end else if (rnd_r < 7'd60) begin
      grp = sha1sh_pkg::GRP_MAJ;
    end else begin
      grp = sha1sh_pkg::GRP_PAR_B;
    end
  end

  logic [31:0] sched_mix;

  always_comb begin
    // window holds W[r-16] at the bottom and W[r-1] at the top
    sched_mix = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    w_cur = (rnd_r < 7'(sha1sh_pkg::BLOCK_WORDS)) ? rd_data_r
                                                   : {sched_mix[30:0], sched_mix[31]};
    t_sum = {a_r[26:0], a_r[31:27]} + sha1sh_pkg::round_f(grp, b_r, c_r, d_r)
          + e_r + sha1sh_pkg::round_k(grp) + w_cur;
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha1sh_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.byte_valid && fill_r == 6'(sha1sh_pkg::BLOCK_BYTES - 1)) begin
            state_nxt = sha1sh_pkg::ST_LOAD;
          end else if (in_bus.end_of_message) begin
            state_nxt = sha1sh_pkg::ST_PAD;
          end
        end
      end
      sha1sh_pkg::ST_PAD: begin
        state_nxt = sha1sh_pkg::ST_ZERO;
      end
      sha1sh_pkg::ST_ZERO: begin
        if (wptr_r[4]) begin
          state_nxt = sha1sh_pkg::ST_LOAD;
        end
      end
      sha1sh_pkg::ST_LOAD: begin
        state_nxt = sha1sh_pkg::ST_COMP;
      end
      sha1sh_pkg::ST_COMP: begin
        if (rnd_r == 7'(sha1sh_pkg::ROUNDS - 1)) begin
          state_nxt = sha1sh_pkg::ST_FIN;
        end
      end
      sha1sh_pkg::ST_FIN: begin
        if (!pad_r) begin
          state_nxt = end_pend_r ? sha1sh_pkg::ST_PAD : sha1sh_pkg::ST_IDLE;
        end else if (extra_r) begin
          state_nxt = sha1sh_pkg::ST_ZERO;
        end else begin
          state_nxt = sha1sh_pkg::ST_OUT;
        end
      end
      sha1sh_pkg::ST_OUT: begin
        if (out_fire && oidx_r == 3'(sha1sh_pkg::DIGEST_WORDS - 1)) begin
          state_nxt = sha1sh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sha1sh_pkg::ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs: handshakes and buffer port controls
  // --------------------------------------------------------------------------
  always_comb begin
    in_bus.ready  = 1'b0;
    out_bus.valid = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = fill_r[5:2];
    mem_wdata     = put_word;
    mem_raddr     = 4'd0;
    case (state_r)
      sha1sh_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        // write the word back once its last byte lands
        mem_we = in_fire & in_bus.byte_valid & (fill_r[1:0] == 2'd3);
      end
      sha1sh_pkg::ST_PAD: begin
        mem_we    = 1'b1;
        mem_wdata = pad_word;
      end
      sha1sh_pkg::ST_ZERO: begin
        mem_we    = !wptr_r[4];
        mem_waddr = wptr_r[3:0];
        if (!extra_r && wptr_r[3:0] == 4'(sha1sh_pkg::LEN_HI_WORD)) begin
          mem_wdata = bitlen_r[63:32];
        end else if (!extra_r && wptr_r[3:0] == 4'(sha1sh_pkg::LEN_LO_WORD)) begin
          mem_wdata = bitlen_r[31:0];
        end else begin
          mem_wdata = 32'd0;
        end
      end
      sha1sh_pkg::ST_LOAD: begin
        mem_raddr = 4'd0;
      end
      sha1sh_pkg::ST_COMP: begin
        // prefetch the next schedule word; beyond word 15 it goes unused
        mem_raddr = rnd_r[3:0] + 4'd1;
      end
      sha1sh_pkg::ST_OUT: begin
        out_bus.valid = 1'b1;
      end
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  assign out_bus.digest_word = h_r[oidx_r];
  assign out_bus.word_index  = oidx_r;
  assign out_bus.last_word   = (oidx_r == 3'(sha1sh_pkg::DIGEST_WORDS - 1));

  // --------------------------------------------------------------------------
  // Datapath next values
  // --------------------------------------------------------------------------
  always_comb begin
    fill_nxt     = fill_r;
    bitlen_nxt   = bitlen_r;
    acc_nxt      = acc_r;
    end_pend_nxt = end_pend_r;
    pad_nxt      = pad_r;
    extra_nxt    = extra_r;
    wptr_nxt     = wptr_r;
    rnd_nxt      = rnd_r;
    oidx_nxt     = oidx_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    d_nxt        = d_r;
    e_nxt        = e_r;
    for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS; i++) begin
      sched_nxt[i] = sched_r[i];
    end
    for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
      h_nxt[i] = h_r[i];
    end

    case (state_r)
      sha1sh_pkg::ST_IDLE: begin
        if (in_fire) begin
          end_pend_nxt = in_bus.end_of_message;
          if (in_bus.byte_valid) begin
            acc_nxt    = put_word;
            fill_nxt   = fill_r + 6'd1;  // wraps to zero on a full block
            bitlen_nxt = bitlen_r + 64'd8;
          end
        end
      end
      sha1sh_pkg::ST_PAD: begin
        pad_nxt   = 1'b1;
        extra_nxt = (fill_r >= 6'(sha1sh_pkg::EXTRA_FILL));
        wptr_nxt  = {1'b0, fill_r[5:2]} + 5'd1;
      end
      sha1sh_pkg::ST_ZERO: begin
        if (!wptr_r[4]) begin
          wptr_nxt = wptr_r + 5'd1;
        end
      end
      sha1sh_pkg::ST_LOAD: begin
        a_nxt   = h_r[0];
        b_nxt   = h_r[1];
        c_nxt   = h_r[2];
        d_nxt   = h_r[3];
        e_nxt   = h_r[4];
        rnd_nxt = 7'd0;
      end
      sha1sh_pkg::ST_COMP: begin
        a_nxt   = t_sum;
        b_nxt   = a_r;
        c_nxt   = {b_r[1:0], b_r[31:2]};
        d_nxt   = c_r;
        e_nxt   = d_r;
        rnd_nxt = rnd_r + 7'd1;
        for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS - 1; i++) begin
          sched_nxt[i] = sched_r[i + 1];
        end
        sched_nxt[sha1sh_pkg::BLOCK_WORDS - 1] = w_cur;
      end
      sha1sh_pkg::ST_FIN: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (pad_r && extra_r) begin
          // length block: zero words 0..13, length in 14 and 15
          extra_nxt = 1'b0;
          wptr_nxt  = 5'd0;
        end
        oidx_nxt = 3'd0;
      end
      sha1sh_pkg::ST_OUT: begin
        if (out_fire) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'(sha1sh_pkg::DIGEST_WORDS - 1)) begin
            // restart for the next message
            fill_nxt     = 6'd0;
            bitlen_nxt   = 64'd0;
            end_pend_nxt = 1'b0;
            pad_nxt      = 1'b0;
            extra_nxt    = 1'b0;
            for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
              h_nxt[i] = sha1sh_pkg::INIT_CHAIN[i];
            end
          end
        end
      end
      default: begin
        pad_nxt = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha1sh_pkg::ST_IDLE;
      fill_r     <= 6'd0;
      bitlen_r   <= 64'd0;
      end_pend_r <= 1'b0;
      pad_r      <= 1'b0;
      extra_r    <= 1'b0;
      wptr_r     <= 5'd0;
      rnd_r      <= 7'd0;
      oidx_r     <= 3'd0;
      for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
        h_r[i] <= sha1sh_pkg::INIT_CHAIN[i];
      end
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      bitlen_r   <= bitlen_nxt;
      end_pend_r <= end_pend_nxt;
      pad_r      <= pad_nxt;
      extra_r    <= extra_nxt;
      wptr_r     <= wptr_nxt;
      rnd_r      <= rnd_nxt;
      oidx_r     <= oidx_nxt;
      for (int i = 0; i < sha1sh_pkg::DIGEST_WORDS; i++) begin
        h_r[i] <= h_nxt[i];
      end
    end
  end

  // working words, schedule window and packing word carry no reset
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    e_r   <= e_nxt;
    for (int i = 0; i < sha1sh_pkg::BLOCK_WORDS; i++) begin
      sched_r[i] <= sched_nxt[i];
    end
  end

endmodule

// ===== hw/rtl/sha1sh_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-1 hasher port checker
// Watches the hasher's channels for digest beat ordering and channel exclusion.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1sh_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [31:0]                       out_digest_word,
  input logic [sha1sh_pkg::WORD_IDX_W-1:0] out_word_index,
  input logic                              out_last_word
);

  localparam logic [sha1sh_pkg::WORD_IDX_W-1:0] LAST_IDX =
    sha1sh_pkg::WORD_IDX_W'(sha1sh_pkg::DIGEST_WORDS - 1);

  // a stalled digest beat holds its payload
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_digest_word) && $stable(out_word_index))

  // digest beats count up without gaps until the last word
  `ASSERT_NEXT(a_idx_step, out_valid && out_ready && !out_last_word, out_valid && (out_word_index == $past(out_word_index) + 1'b1))

  // the last flag marks exactly the final index
  `ASSERT_SAME(a_last_idx, out_valid, out_last_word == (out_word_index == LAST_IDX))

  // no byte is taken while a digest is being emitted, and the next message
  // may start right after the final beat
  `ASSERT_SAME(a_excl, out_valid, !in_ready)
  `ASSERT_NEXT(a_reopen, out_valid && out_ready && out_last_word, in_ready)

endmodule

bind sha1_stream_hasher sha1sh_checker u_sha1sh_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_digest_word (out_bus.digest_word),
  .out_word_index  (out_bus.word_index),
  .out_last_word   (out_bus.last_word)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Streams byte-serial messages into the hasher and checks every digest beat
// against a SHA-1 predictor held in the bench. Short directed messages come
// first, then random messages under four sender and receiver idling phases.
// Some message lengths put the pad byte on each side of byte 56 and on a block
// edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // One expected digest beat, as it should leave on out_bus.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  word_idx;
    logic        last;
  } digest_beat_t;

  // Chaining values at the start of every message, kept apart from the RTL copy.
  localparam logic [31:0] SHA1_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam int PHASE_ITEMS = 50;

  logic clk;
  logic rst_n;

  sha1sh_in_if  in_bus();
  sha1sh_out_if out_bus();

  sha1_stream_hasher dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Predictor state: chain, block buffer, fill and running bit length.
  logic [31:0]  hash_chain [5];
  logic [31:0]  hash_block [16];
  int unsigned  hash_fill;
  logic [63:0]  hash_bits;

  digest_beat_t pending_digest [$];
  int           digest_words_due;
  int           phase_items;
  int           fail_count;
  int           send_idle_pct;
  int           recv_stall_pct;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run well beyond the slowest legal schedule.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rotl32(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Return to the initial chain for the next message.
  function automatic void sha1_restart();
    for (int i = 0; i < 5; i++) hash_chain[i] = SHA1_IV[i];
    for (int i = 0; i < 16; i++) hash_block[i] = 32'h0;
    hash_fill = 0;
    hash_bits = 64'h0;
  endfunction

  // Run the 80 rounds over the buffered block and fold into the chain.
  function automatic void sha1_compress();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) sched[r] = hash_block[r];
    for (int r = 16; r < 80; r++)
      sched[r] = rotl32(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    e = hash_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5a827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ed9eba1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d;
        k = 32'hca62c1d6;
      end
      t = rotl32(a, 5) + f + e + k + sched[r];
      e = d;
      d = c;
      c = rotl32(b, 30);
      b = a;
      a = t;
    end
    hash_chain[0] += a;
    hash_chain[1] += b;
    hash_chain[2] += c;
    hash_chain[3] += d;
    hash_chain[4] += e;
  endfunction

  // Place a byte big-endian at the fill position; clear a word as it starts.
  function automatic void sha1_put_byte(logic [7:0] value);
    int unsigned widx;
    int unsigned shift;
    widx  = (hash_fill >> 2) & 15;
    shift = 24 - 8 * (hash_fill & 3);
    if ((hash_fill & 3) == 0) hash_block[widx] = 32'h0;
    hash_block[widx] |= 32'(value) << shift;
    hash_fill++;
  endfunction

  // Absorb one accepted input beat; queue the digest when it closes a message.
  function automatic void sha1_absorb(logic [7:0] value, logic has_byte, logic eom);
    if (has_byte) begin
      sha1_put_byte(value);
      hash_bits += 64'd8;
      if (hash_fill >= 64) begin
        sha1_compress();
        hash_fill = 0;
      end
    end
    if (eom) begin
      sha1_put_byte(8'h80);
      for (int i = (hash_fill + 3) >> 2; i < 16; i++) hash_block[i] = 32'h0;
      // Pad byte at or past byte 56: no room for the length, so spend a block on it.
      if (hash_fill > 56) begin
        sha1_compress();
        for (int i = 0; i < 16; i++) hash_block[i] = 32'h0;
      end
      hash_block[14] = hash_bits[63:32];
      hash_block[15] = hash_bits[31:0];
      sha1_compress();
      for (int i = 0; i < 5; i++)
        pending_digest.push_back('{hash_chain[i], 3'(i), (i == 4)});
      digest_words_due += 5;
      sha1_restart();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Digest beat checker and receiver stall
  // --------------------------------------------------------------------------
  // Sample at the edge, before any update lands, and redraw ready once per edge.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin : check_beat
      digest_beat_t due;
      if (pending_digest.size() == 0) begin
        $error("digest beat with none due: digest_word %h word_index %0d",
               out_bus.digest_word, out_bus.word_index);
        fail_count++;
      end else begin
        due = pending_digest.pop_front();
        if (out_bus.digest_word !== due.word) begin
          $error("digest_word expected %h actual %h", due.word, out_bus.digest_word);
          fail_count++;
        end
        if (out_bus.word_index !== due.word_idx) begin
          $error("word_index expected %0d actual %0d", due.word_idx, out_bus.word_index);
          fail_count++;
        end
        if (out_bus.last_word !== due.last) begin
          $error("last_word expected %0b actual %0b", due.last, out_bus.last_word);
          fail_count++;
        end
      end
    end
    out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Drive one beat and hold it until accepted. Valid stays high into the next
  // beat unless a gap is drawn, so it is never dropped and raised in one step.
  task automatic send_beat(logic [7:0] value, logic has_byte, logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.data_byte      <= value;
    in_bus.byte_valid     <= has_byte;
    in_bus.end_of_message <= eom;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sha1_absorb(value, has_byte, eom);
  endtask

  // Send a whole message of random bytes, with the odd empty beat mixed in.
  // The closing flag either rides on the last byte or comes on a beat of its own.
  task automatic send_message(int unsigned len);
    logic ride;
    ride = (len > 0) && $urandom_range(0, 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(8'($urandom), 1'b1, ride && (i == len - 1));
      phase_items++;
    end
    if (!ride) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
      phase_items++;
    end
  endtask

  // Hand-picked messages: empty beats, empty message, single bytes at the
  // extremes, a closing beat with no byte, a gap inside a message.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(8'h5a, 1'b0, 1'b0);   // no byte, no end: nothing happens
    send_beat(8'hff, 1'b0, 1'b1);   // empty message, data ignored
    send_beat(8'hff, 1'b0, 1'b1);   // back-to-back empty message
    send_beat(8'h00, 1'b1, 1'b1);   // single zero byte on the end beat
    send_beat(8'hff, 1'b1, 1'b0);   // single 0xff, closed without a byte
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);   // "abc"
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'h12, 1'b1, 1'b0);   // empty beat in the middle of a message
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'h34, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
  endtask

  // One idling phase: lead with a message that lands the pad at a chosen fill,
  // then random lengths, mostly short. Carry on until the phase has its share
  // of beats and, where asked, enough digest words have been due overall.
  task automatic test_random_phase(int send_pct, int stall_pct, int unsigned edge_len,
                                   int min_words);
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    phase_items    = 0;
    send_message(edge_len);
    while (phase_items < PHASE_ITEMS || digest_words_due < min_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      send_message($urandom_range(0, 20));
      else if (pick < 88) send_message($urandom_range(21, 54));
      else if (pick < 95) send_message($urandom_range(55, 65));
      else                send_message($urandom_range(118, 130));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    fail_count       = 0;
    digest_words_due = 0;
    phase_items      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    sha1_restart();
    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.data_byte      <= 8'h00;
    in_bus.byte_valid     <= 1'b0;
    in_bus.end_of_message <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    // Pad lands: just fits (55), needs a length block (56 and 63), after a
    // full block (64).
    test_random_phase(0, 0, 55, 0);
    test_random_phase(70, 0, 56, 0);
    test_random_phase(0, 70, 63, 0);
    test_random_phase(37, 37, 64, 60);
    in_bus.valid <= 1'b0;

    // Drain outstanding digests, then let the block settle.
    while (pending_digest.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
